FILE: rtl/core/fubp_pkg.sv
package fubp_pkg;

  // Staging buffer geometry
  localparam int unsigned SECTOR_COUNT = 4;
  localparam int unsigned SECTOR_BYTES = 16384;

  // Sector select is at least two bits wide so the program sector field always fits
  localparam int unsigned SEL_W = ($clog2(SECTOR_COUNT) > 2) ? $clog2(SECTOR_COUNT) : 2;
  localparam int unsigned BC_W  = $clog2(SECTOR_BYTES + 1);

  // End-of-upload string
  localparam int unsigned END_LEN = 9;
  localparam int unsigned MP_W    = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MAGIC = 2'd0;
  localparam logic [1:0] CFG_START_ACK   = 2'd1;
  localparam logic [1:0] CFG_END_ACK     = 2'd2;

  // Host access kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_READ = 3'd1,
    PH_INDEX      = 3'd2,
    PH_INDEX_READ = 3'd3,
    PH_DATA       = 3'd4,
    PH_SUM_READ   = 3'd5,
    PH_END_READ   = 3'd6
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] write_data;
  } host_t;

  typedef struct packed {
    logic        read_ok;
    logic [7:0]  read_data;
    logic        store_valid;
    logic [15:0] store_address;
    logic [7:0]  store_data;
    logic        program_request;
    logic [1:0]  program_sector;
    logic        session_active;
  } result_t;

  // Character of the end string at a given match position
  function automatic logic [7:0] end_char(input logic [MP_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h4B;
      4'd1:    c = 8'h46;
      4'd2:    c = 8'h53;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h44;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h45;
      4'd7:    c = 8'h4E;
      4'd8:    c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/firmware_upload_byte_protocol.sv
// An accepted host word's result enters the result register, or the skid entry
// while the result side stalls. One host word per cycle while host_stall is low;
// the session update is combinational logic between session and result registers.
// A two-entry output stage (result register plus skid) keeps host_stall registered.
// Reset (rst, synchronous) ends any session, empties the output stage and
// clears the configuration registers to 0.
module firmware_upload_byte_protocol
  import fubp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       host_valid,
  output logic       host_stall,
  input  host_t      host,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers
  logic [7:0] start_magic;
  logic [7:0] start_ack;
  logic [7:0] end_ack;

  // Session state
  logic              active_flag;
  phase_t            phase;
  logic [7:0]        reply_byte;
  logic              reply_pending;
  phase_t            phase_after_reply;
  logic [SEL_W-1:0]  sector_sel;
  logic [BC_W-1:0]   byte_count;
  logic [7:0]        xor_sum;
  logic [MP_W-1:0]   match_pos;

  logic              active_flag_next;
  phase_t            phase_next;
  logic [7:0]        reply_byte_next;
  logic              reply_pending_next;
  phase_t            phase_after_reply_next;
  logic [SEL_W-1:0]  sector_sel_next;
  logic [BC_W-1:0]   byte_count_next;
  logic [7:0]        xor_sum_next;
  logic [MP_W-1:0]   match_pos_next;

  // Output stage
  result_t result_next;
  result_t skid;
  logic    skid_valid;

  logic    host_accept;
  logic    result_take;

  logic [7:0]      v;
  logic [MP_W-1:0] match_inc;
  logic            char_hit;
  logic            end_hit;
  logic            index_ok;
  logic            last_byte;
  logic [31:0]     addr_full;

  assign host_stall  = skid_valid;
  assign host_accept = host_valid & ~skid_valid;
  assign result_take = result_valid & ~result_stall;

  assign v         = host.write_data;
  assign match_inc = match_pos + MP_W'(1);
  assign char_hit  = (match_pos < MP_W'(END_LEN)) && (v == end_char(match_pos));
  assign end_hit   = char_hit && (match_inc == MP_W'(END_LEN));
  assign index_ok  = v < 8'(SECTOR_COUNT);
  assign last_byte = byte_count == BC_W'(SECTOR_BYTES - 1);
  assign addr_full = 32'(sector_sel) * 32'(SECTOR_BYTES) + 32'(byte_count);

  // Next session state for one host word
  always_comb begin
    active_flag_next       = active_flag;
    phase_next             = phase;
    reply_byte_next        = reply_byte;
    reply_pending_next     = reply_pending;
    phase_after_reply_next = phase_after_reply;
    sector_sel_next        = sector_sel;
    byte_count_next        = byte_count;
    xor_sum_next           = xor_sum;
    match_pos_next         = match_pos;

    if (host.mode == MODE_READ) begin
      // Hand out the queued reply and move on
      if (active_flag && reply_pending) begin
        reply_pending_next = 1'b0;
        if (phase_after_reply == PH_END_READ) begin
          active_flag_next = 1'b0;
          phase_next       = PH_IDLE;
        end else begin
          phase_next = phase_after_reply;
        end
      end
    end else if (!active_flag) begin
      // Arm on the start magic
      if (v == start_magic) begin
        active_flag_next       = 1'b1;
        phase_next             = PH_START_READ;
        match_pos_next         = '0;
        reply_byte_next        = start_ack;
        reply_pending_next     = 1'b1;
        phase_after_reply_next = PH_INDEX;
      end
    end else if (phase == PH_INDEX) begin
      // Track the end string, restarting on the first character
      if (char_hit) begin
        match_pos_next = match_inc;
      end else begin
        match_pos_next = (v == end_char('0)) ? MP_W'(1) : MP_W'(0);
      end
      if (end_hit) begin
        phase_next             = PH_END_READ;
        reply_byte_next        = end_ack;
        reply_pending_next     = 1'b1;
        phase_after_reply_next = PH_END_READ;
      end else if (index_ok) begin
        sector_sel_next        = v[SEL_W-1:0];
        byte_count_next        = '0;
        xor_sum_next           = '0;
        phase_next             = PH_INDEX_READ;
        reply_byte_next        = v;
        reply_pending_next     = 1'b1;
        phase_after_reply_next = PH_DATA;
      end
    end else if (phase == PH_DATA) begin
      // Fold the data byte and close the sector on its last byte
      xor_sum_next    = xor_sum ^ v;
      byte_count_next = byte_count + BC_W'(1);
      if (last_byte) begin
        phase_next             = PH_SUM_READ;
        reply_byte_next        = xor_sum ^ v;
        reply_pending_next     = 1'b1;
        phase_after_reply_next = PH_INDEX;
      end
    end
  end

  // Result word for one host word
  always_comb begin
    result_next = '0;
    if (host.mode == MODE_READ) begin
      if (active_flag) begin
        result_next.read_ok = 1'b1;
        if (reply_pending) begin
          result_next.read_data = reply_byte;
        end
      end
    end else if (active_flag && phase == PH_DATA) begin
      result_next.store_valid   = 1'b1;
      result_next.store_address = addr_full[15:0];
      result_next.store_data    = v;
      if (last_byte) begin
        result_next.program_request = 1'b1;
        result_next.program_sector  = sector_sel[1:0];
      end
    end
    result_next.session_active = active_flag_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_magic <= '0;
      start_ack   <= '0;
      end_ack     <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_START_MAGIC: start_magic <= cfg_data;
        CFG_START_ACK:   start_ack   <= cfg_data;
        CFG_END_ACK:     end_ack     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Advance session state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag       <= 1'b0;
      phase             <= PH_IDLE;
      reply_byte        <= '0;
      reply_pending     <= 1'b0;
      phase_after_reply <= PH_IDLE;
      sector_sel        <= '0;
      byte_count        <= '0;
      xor_sum           <= '0;
      match_pos         <= '0;
    end else if (host_accept) begin
      active_flag       <= active_flag_next;
      phase             <= phase_next;
      reply_byte        <= reply_byte_next;
      reply_pending     <= reply_pending_next;
      phase_after_reply <= phase_after_reply_next;
      sector_sel        <= sector_sel_next;
      byte_count        <= byte_count_next;
      xor_sum           <= xor_sum_next;
      match_pos         <= match_pos_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_take) begin
        skid_valid <= 1'b0;
      end
    end else if (host_accept) begin
      if (!result_valid || result_take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result_take) begin
      result_valid <= 1'b0;
    end
  end

  // Output payload: refill from skid or from the new word
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_take) begin
        result <= skid;
      end
    end else if (host_accept) begin
      if (!result_valid || result_take) begin
        result <= result_next;
      end else begin
        skid <= result_next;
      end
    end
  end

endmodule

FILE: test/firmware_upload_byte_protocol_tb.sv
module firmware_upload_byte_protocol_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fubp_pkg::*;

  localparam int PERIOD       = 20;
  localparam int WATCHDOG     = 2000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 4;
  localparam int SETUPS       = 5;
  localparam int SESSIONS_PER = 4;
  localparam int DATA_N       = 500;
  localparam int DIR_N        = 24;

  // End-of-upload string, first character in the top byte
  localparam logic [71:0] END_STR = 72'h4B_46_53_49_44_5F_45_4E_44;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       typed;
    logic       rd_ok;
    logic [7:0] rd;
    logic       act;
  } probe_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       host_valid = 1'b0;
  logic       host_stall;
  host_t      host = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_en = 1'b0;
  logic [1:0] cfg_index = CFG_START_MAGIC;
  logic [7:0] cfg_data = 8'h00;

  // Session model
  logic             sess_on = 1'b0;
  phase_t           ph = PH_IDLE;
  logic [7:0]       reply = 8'h00;
  logic             reply_due = 1'b0;
  phase_t           ph_next = PH_IDLE;
  logic [SEL_W-1:0] sector = '0;
  logic [BC_W-1:0]  nbytes = '0;
  logic [7:0]       csum = 8'h00;
  logic [MP_W-1:0]  mpos = '0;
  logic [7:0]       magic_r = 8'h00;
  logic [7:0]       sack_r = 8'h00;
  logic [7:0]       eack_r = 8'h00;

  result_t due_results [$];
  probe_t  probes [DIR_N];

  logic quiet = 1'b0;
  logic held = 1'b0;
  int   sent_words = 0;
  int   checked = 0;
  int   stored = 0;
  int   bad_count = 0;
  int   sessions = 0;
  int   stuck_cycles = 0;

  firmware_upload_byte_protocol u_dut (
    .clk(clk),
    .rst(rst),
    .host_valid(host_valid),
    .host_stall(host_stall),
    .host(host),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] end_byte(input int pos);
    return END_STR[71 - 8 * pos -: 8];
  endfunction

  function automatic void queue_reply(input logic [7:0] v, input phase_t nxt);
    reply = v;
    reply_due = 1'b1;
    ph_next = nxt;
  endfunction

  // Advance the session model by one host word and return the result word it causes
  function automatic result_t upload_step(input host_t w);
    result_t     r;
    int unsigned addr;
    logic        hit;
    r = '0;
    hit = 1'b0;
    if (w.mode == MODE_READ) begin
      if (sess_on) begin
        r.read_ok = 1'b1;
        if (reply_due) begin
          r.read_data = reply;
          reply_due = 1'b0;
          ph = ph_next;
          if (ph == PH_END_READ) begin
            sess_on = 1'b0;
            ph = PH_IDLE;
          end
        end
      end
    end else if (!sess_on) begin
      if (w.write_data == magic_r) begin
        sess_on = 1'b1;
        ph = PH_START_READ;
        mpos = '0;
        queue_reply(sack_r, PH_INDEX);
      end
    end else if (ph == PH_INDEX) begin
      // Track the end string; a mismatch restarts at one on the first character
      if (mpos < END_LEN && w.write_data == end_byte(int'(mpos))) begin
        mpos = mpos + 1'b1;
        hit = (mpos == END_LEN);
      end else begin
        mpos = (w.write_data == end_byte(0)) ? MP_W'(1) : MP_W'(0);
      end
      if (hit) begin
        ph = PH_END_READ;
        queue_reply(eack_r, PH_END_READ);
      end else if (w.write_data < SECTOR_COUNT) begin
        sector = w.write_data[SEL_W-1:0];
        nbytes = '0;
        csum = 8'h00;
        ph = PH_INDEX_READ;
        queue_reply(w.write_data, PH_DATA);
      end
    end else if (ph == PH_DATA) begin
      addr = sector * SECTOR_BYTES + nbytes;
      r.store_valid = 1'b1;
      r.store_address = addr[15:0];
      r.store_data = w.write_data;
      csum = csum ^ w.write_data;
      nbytes = nbytes + 1'b1;
      if (nbytes >= SECTOR_BYTES) begin
        r.program_request = 1'b1;
        r.program_sector = sector[1:0];
        ph = PH_SUM_READ;
        queue_reply(csum, PH_INDEX);
      end
    end
    r.session_active = sess_on;
    return r;
  endfunction

  // Pick the next host word from the current session phase; goal < 0 heads for the end string
  function automatic host_t next_word(input int goal);
    host_t       w;
    int unsigned roll;
    w.mode = MODE_WRITE;
    w.write_data = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (!sess_on) begin
      if (roll < 55) w.write_data = magic_r;
      else if (roll < 75) w.mode = MODE_READ;
    end else begin
      case (ph)
        PH_INDEX: begin
          if (roll < 12) w.mode = MODE_READ;
          else if (roll < 24) w.write_data = end_byte(0);
          else if (roll < 36) w.write_data = 8'($urandom_range(SECTOR_COUNT, 255));
          else if (goal < 0) w.write_data = end_byte(int'(mpos));
          else if (roll < 60 && mpos < END_LEN - 1) w.write_data = end_byte(int'(mpos));
          else w.write_data = 8'(goal);
        end
        PH_DATA: begin
          if (roll < 3) w.mode = MODE_READ;
        end
        default: begin
          if (roll < 80) w.mode = MODE_READ;
        end
      endcase
    end
    return w;
  endfunction

  // Offer one host word, hold it until accepted, then record what it should produce
  task automatic send_word(input host_t w, input logic typed, input result_t want);
    result_t r;
    host <= w;
    host_valid <= 1'b1;
    do @(posedge clk); while (host_stall);
    sent_words++;
    r = upload_step(w);
    due_results.push_back(typed ? want : r);
    if (!quiet && $urandom_range(0, 29) == 0) begin
      host_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result word is back
  task automatic settle();
    host_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(input logic [7:0] magic, input logic [7:0] sack,
                           input logic [7:0] eack);
    cfg_en <= 1'b1;
    cfg_index <= CFG_START_MAGIC;
    cfg_data <= magic;
    @(posedge clk);
    cfg_index <= CFG_START_ACK;
    cfg_data <= sack;
    @(posedge clk);
    cfg_index <= CFG_END_ACK;
    cfg_data <= eack;
    @(posedge clk);
    cfg_en <= 1'b0;
    magic_r = magic;
    sack_r = sack;
    eack_r = eack;
  endtask

  // Run one session from idle to end acknowledge without selecting a sector
  task automatic run_session();
    host_t w;
    logic  seen;
    seen = 1'b0;
    while (!(seen && !sess_on)) begin
      w = next_word(-1);
      send_word(w, 1'b0, '0);
      if (sess_on) seen = 1'b1;
    end
  endtask

  // Open a session, select a random sector and stream part of it
  task automatic data_run(input int n);
    host_t w;
    int    goal;
    int    i;
    goal = $urandom_range(0, SECTOR_COUNT - 1);
    while (ph != PH_DATA) begin
      w = next_word(goal);
      send_word(w, 1'b0, '0);
    end
    for (i = 0; i < n; i++) begin
      w = next_word(goal);
      send_word(w, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    probe_t  row;
    host_t   w;
    result_t want;
    int      k;
    int      s;
    probes = '{
      '{MODE_READ,  8'hC3, 1'b1, 1'b0, 8'h00, 1'b0},  // read while inactive
      '{MODE_WRITE, 8'h01, 1'b1, 1'b0, 8'h00, 1'b0},  // not the start magic
      '{MODE_WRITE, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1},  // start magic at reset value
      '{MODE_WRITE, 8'h55, 1'b1, 1'b0, 8'h00, 1'b1},  // write while ack waits
      '{MODE_READ,  8'hFF, 1'b1, 1'b1, 8'h00, 1'b1},  // start ack
      '{MODE_READ,  8'h00, 1'b1, 1'b1, 8'h00, 1'b1},  // nothing queued
      '{MODE_WRITE, 8'h4B, 1'b1, 1'b0, 8'h00, 1'b1},
      '{MODE_WRITE, 8'h4B, 1'b1, 1'b0, 8'h00, 1'b1},  // mismatch on first character
      '{MODE_WRITE, 8'h46, 1'b1, 1'b0, 8'h00, 1'b1},
      '{MODE_WRITE, 8'h07, 1'b1, 1'b0, 8'h00, 1'b1},  // index out of range
      '{MODE_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1},
      '{MODE_WRITE, 8'h4B, 1'b0, 1'b0, 8'h00, 1'b0},  // full end string
      '{MODE_WRITE, 8'h46, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h53, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h49, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h44, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h5F, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h45, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h4E, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h44, 1'b0, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'h03, 1'b1, 1'b0, 8'h00, 1'b1},  // write while end ack waits
      '{MODE_READ,  8'h5A, 1'b1, 1'b1, 8'h00, 1'b0},  // end ack closes session
      '{MODE_READ,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{MODE_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table under the reset register values
    for (k = 0; k < DIR_N; k++) begin
      row = probes[k];
      w.mode = row.mode;
      w.write_data = row.data;
      want = '0;
      want.read_ok = row.rd_ok;
      want.read_data = row.rd;
      want.session_active = row.act;
      send_word(w, row.typed, want);
    end
    sessions++;

    // Random sessions under several register setups, the last one without idling
    for (k = 0; k < SETUPS; k++) begin
      settle();
      case (k)
        0: load_regs(8'hFF, 8'hFF, 8'hFF);
        1: load_regs(8'h00, 8'h00, 8'hFF);
        2: load_regs(8'h4B, 8'h01, 8'h80);
        default: load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      if (k == SETUPS - 1) quiet = 1'b1;
      for (s = 0; s < SESSIONS_PER; s++) begin
        run_session();
        sessions++;
      end
    end

    // Stream part of one sector to exercise the staging buffer path
    data_run(DATA_N);
    sessions++;

    settle();
    $display("Covered %0d host words in %0d sessions over %0d register setups",
             sent_words, sessions, SETUPS + 1);
    $display("Checked %0d result words, %0d buffer stores, %0d mismatches",
             checked, stored, bad_count);
    if (bad_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Stall the result side in random bursts, plus one long hold-off mid run
  initial begin : result_side
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!quiet && !held && sent_words >= HOLD_AT) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result word against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      checked++;
      if (result.store_valid) stored++;
      if (due_results.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("ERROR: result word with none expected: %h", result);
      end else begin
        want = due_results.pop_front();
        if (result.read_ok !== want.read_ok || result.read_data !== want.read_data ||
            result.store_valid !== want.store_valid ||
            result.store_address !== want.store_address ||
            result.store_data !== want.store_data ||
            result.program_request !== want.program_request ||
            result.program_sector !== want.program_sector ||
            result.session_active !== want.session_active) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("ERROR: word %0d exp ok=%b rd=%h st=%b addr=%h sd=%h pr=%b ps=%0d act=%b",
                     checked, want.read_ok, want.read_data, want.store_valid,
                     want.store_address, want.store_data, want.program_request,
                     want.program_sector, want.session_active);
            $display("       got ok=%b rd=%h st=%b addr=%h sd=%h pr=%b ps=%0d act=%b",
                     result.read_ok, result.read_data, result.store_valid,
                     result.store_address, result.store_data, result.program_request,
                     result.program_sector, result.session_active);
          end
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin : watchdog
    if ((host_valid && !host_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == WATCHDOG) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
